// ===== rtl/s4c_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s4c_pkg: shared constants for the skip-four number converter
// Field widths, the default digit count and the request codes.
// ----------------------------------------------------------------------------
package s4c_pkg;

	localparam int CNT_W          = 51;  // ordinary count width
	localparam int DIG_W          = 64;  // packed BCD digit field width
	localparam int NDIG_W         = 5;   // digit count width
	localparam int STEP_W         = 6;   // step counter, holds CNT_W
	localparam int NUM_DIGITS_DEF = 16;

	localparam logic REQ_TO_DIGITS = 1'b0;
	localparam logic REQ_TO_COUNT  = 1'b1;

endpackage

// ===== rtl/s4c_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s4c_req_if / s4c_rsp_if: request and result channels
// Valid/ready handshake; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface s4c_req_if import s4c_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [CNT_W-1:0]  count_in;
	logic [DIG_W-1:0]  digits_in;

	modport source (output valid, output req_type, output count_in, output digits_in,
		input ready);
	modport sink (input valid, input req_type, input count_in, input digits_in,
		output ready);
endinterface

interface s4c_rsp_if import s4c_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CNT_W-1:0]  count_out;
	logic [DIG_W-1:0]  digits_out;
	logic [NDIG_W-1:0] digit_count;
	logic              bad_input;

	modport source (output valid, output count_out, output digits_out,
		output digit_count, output bad_input, input ready);
	modport sink (input valid, input count_out, input digits_out,
		input digit_count, input bad_input, output ready);
endinterface

// ===== rtl/skip_four_number_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skip_four_number_converter: count <-> skip-four (base 9) digit conversion
//
//   channel | dir | fields
//   req     | in  | req_type, count_in, digits_in
//   rsp     | out | count_out, digits_out, digit_count, bad_input
//
// Count to digits shifts one count bit per cycle through the base-9
// lanes; digits to count takes one digit per cycle through the
// accumulator; the result is then loaded into the output register.
// One item is in work at a time; req is taken while a result waits on rsp.
// A stalled rsp holds the finished item in the engine until the slot frees.
// Reset clears control state only.
// ----------------------------------------------------------------------------
module skip_four_number_converter import s4c_pkg::*; #(
	parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	s4c_req_if.sink   req,
	s4c_rsp_if.source rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0]              state_q;
	logic                    mode_q;
	logic [STEP_W-1:0]       cnt_q;
	logic [STEP_W-1:0]       last;
	logic                    accept;
	logic                    run;
	logic                    load;
	logic [4*NUM_DIGITS-1:0] dbl_digits;
	logic [NDIG_W-1:0]       dbl_ndig;
	logic                    dbl_ovf;
	logic [CNT_W-1:0]        hor_count;
	logic                    hor_bad;
	logic                    out_valid_q;
	logic [CNT_W-1:0]        count_q;
	logic [DIG_W-1:0]        digits_q;
	logic [NDIG_W-1:0]       ndig_q;
	logic                    bad_q;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign run       = (state_q == ST_RUN);
	assign load      = (state_q == ST_WAIT) && (!out_valid_q || rsp.ready);
	assign last      = (mode_q == REQ_TO_COUNT) ? STEP_W'(NUM_DIGITS - 1) : STEP_W'(CNT_W - 1);

	s4c_dbl #(.N(NUM_DIGITS)) u_dbl (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (accept),
		.step   (run && mode_q == REQ_TO_DIGITS),
		.count  (req.count_in),
		.digits (dbl_digits),
		.ndig   (dbl_ndig),
		.ovf    (dbl_ovf)
	);

	s4c_horner #(.N(NUM_DIGITS)) u_horner (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (accept),
		.step   (run && mode_q == REQ_TO_COUNT),
		.digits (req.digits_in[4*NUM_DIGITS-1:0]),
		.count  (hor_count),
		.bad    (hor_bad)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= REQ_TO_DIGITS;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q  <= req.req_type;
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + STEP_W'(1);
					if (cnt_q == last) state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (mode_q == REQ_TO_COUNT) begin
				count_q  <= hor_bad ? '0 : hor_count;
				digits_q <= '0;
				ndig_q   <= '0;
				bad_q    <= hor_bad;
			end else begin
				count_q  <= '0;
				digits_q <= dbl_ovf ? '0 : DIG_W'(dbl_digits);
				ndig_q   <= dbl_ovf ? '0 : dbl_ndig;
				bad_q    <= dbl_ovf;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.count_out   = count_q;
	assign rsp.digits_out  = digits_q;
	assign rsp.digit_count = ndig_q;
	assign rsp.bad_input   = bad_q;

endmodule

// ===== rtl/s4c_dbl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s4c_dbl: binary to base-9 converter, one count bit per cycle
// Shifts the count in MSB first; every base-9 lane doubles and adds the
// carry from below, folding back by nine.
// ----------------------------------------------------------------------------
module s4c_dbl import s4c_pkg::*; #(
	parameter int N = NUM_DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr,
	input  logic              step,
	input  logic [CNT_W-1:0]  count,
	output logic [4*N-1:0]    digits,
	output logic [NDIG_W-1:0] ndig,
	output logic              ovf
);

	logic [CNT_W-1:0] sh_q;
	logic [3:0]       lane_q [N];
	logic [3:0]       lane_nxt [N];
	logic             carry_out;
	logic             ovf_q;

	always_comb begin
		logic       c;
		logic [4:0] t;
		c = sh_q[CNT_W-1];
		t = '0;
		for (int k = 0; k < N; k++) begin
			t = {lane_q[k], 1'b0} + {4'd0, c};
			if (t >= 5'd9) begin
				lane_nxt[k] = 4'(t - 5'd9);
				c = 1'b1;
			end else begin
				lane_nxt[k] = t[3:0];
				c = 1'b0;
			end
		end
		carry_out = c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (clr) begin
			ovf_q <= 1'b0;
		end else if (step && carry_out) begin
			ovf_q <= 1'b1;   // count reached 9^N
		end
	end

	always_ff @(posedge clk) begin
		if (clr) begin
			sh_q <= count;
			for (int k = 0; k < N; k++) lane_q[k] <= 4'd0;
		end else if (step) begin
			sh_q <= {sh_q[CNT_W-2:0], 1'b0};
			for (int k = 0; k < N; k++) lane_q[k] <= lane_nxt[k];
		end
	end

	// skip-four symbols and the highest nonzero lane
	always_comb begin
		ndig = NDIG_W'(1);
		for (int k = 0; k < N; k++) begin
			digits[4*k +: 4] = (lane_q[k] >= 4'd4) ? lane_q[k] + 4'd1 : lane_q[k];
			if (lane_q[k] != 4'd0) ndig = NDIG_W'(k + 1);
		end
	end

	assign ovf = ovf_q;

endmodule

// ===== rtl/s4c_horner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s4c_horner: skip-four digits to count, one digit per cycle
// Takes the digits MSB first and accumulates acc*9 + value, flagging bad digits.
// ----------------------------------------------------------------------------
module s4c_horner import s4c_pkg::*; #(
	parameter int N = NUM_DIGITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  logic             step,
	input  logic [4*N-1:0]   digits,
	output logic [CNT_W-1:0] count,
	output logic             bad
);

	logic [4*N-1:0]   dsh_q;
	logic [CNT_W-1:0] acc_q;
	logic             bad_q;
	logic [3:0]       d;
	logic [3:0]       dv;

	assign d  = dsh_q[4*N-1 -: 4];
	assign dv = (d > 4'd4) ? d - 4'd1 : d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q <= 1'b0;
		end else if (clr) begin
			bad_q <= 1'b0;
		end else if (step && (d == 4'd4 || d > 4'd9)) begin
			bad_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr) begin
			dsh_q <= digits;
			acc_q <= '0;
		end else if (step) begin
			if (N > 1) dsh_q <= dsh_q << 4;
			acc_q <= acc_q + {acc_q[CNT_W-4:0], 3'b000} + CNT_W'(dv);
		end
	end

	assign count = acc_q;
	assign bad   = bad_q;

endmodule

// ===== verif/tb_skip_four_number_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_skip_four_number_converter: self-checking bench for the skip-four converter
// Directed corner items, then random items under three sender/receiver idle
// mixes and one long receiver hold-off. Every result is checked field by
// field against an in-order queue filled by a behavioral converter.
// ----------------------------------------------------------------------------
module tb_skip_four_number_converter;
	import s4c_pkg::*;

	localparam int          NUM_DIGITS    = NUM_DIGITS_DEF;
	localparam int          HALF_PERIOD   = 6;
	localparam int          HOLD_CYCLES   = 400;
	localparam int          DRAIN_CYCLES  = 60;     // longest conversion plus handover
	localparam int          CYCLE_LIMIT   = 400000;
	localparam logic [3:0]  SKIPPED_DIGIT = 4'd4;
	localparam logic [3:0]  MAX_DIGIT     = 4'd9;

	typedef struct packed {
		logic              req_type;
		logic [CNT_W-1:0]  count_in;
		logic [DIG_W-1:0]  digits_in;
	} conv_req_t;

	typedef struct packed {
		logic [CNT_W-1:0]  count_out;
		logic [DIG_W-1:0]  digits_out;
		logic [NDIG_W-1:0] digit_count;
		logic              bad_input;
	} conv_rsp_t;

	logic clk;
	logic arst_n;

	s4c_req_if req_ch();
	s4c_rsp_if rsp_ch();

	skip_four_number_converter #(.NUM_DIGITS(NUM_DIGITS)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	conv_rsp_t   expected_results[$];
	conv_rsp_t   got_result;
	conv_rsp_t   want_result;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned hold_seq = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;

	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [63:0] pow9(input int unsigned k);
		logic [63:0] p;
		p = 64'd1;
		for (int unsigned i = 0; i < k; i++)
			p = p * 64'd9;
		return p;
	endfunction

	// behavioral converter: one result per request
	function automatic conv_rsp_t convert_expected(input conv_req_t r);
		conv_rsp_t   e;
		logic [63:0] v;
		logic [63:0] acc;
		logic [3:0]  d;
		int unsigned nd;
		bit          bad;
		e   = '0;
		nd  = 0;
		acc = '0;
		bad = 1'b0;
		if (r.req_type == REQ_TO_DIGITS) begin
			if (64'(r.count_in) >= pow9(NUM_DIGITS)) begin
				bad = 1'b1;
			end else begin
				v = 64'(r.count_in);
				do begin
					d = 4'(v % 64'd9);
					if (d >= SKIPPED_DIGIT)
						d = d + 4'd1;
					e.digits_out[4*nd +: 4] = d;
					nd++;
					v = v / 64'd9;
				end while (v != 0 && nd < 16);
				e.digit_count = NDIG_W'(nd);
			end
		end else begin
			for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
				d = r.digits_in[4*i +: 4];
				if (d == SKIPPED_DIGIT || d > MAX_DIGIT) begin
					bad = 1'b1;
					break;
				end
				if (d > SKIPPED_DIGIT)
					d = d - 4'd1;
				acc = acc * 64'd9 + 64'(d);
			end
			e.count_out = acc[CNT_W-1:0];
		end
		if (bad) begin
			e = '0;
			e.bad_input = 1'b1;
		end
		return e;
	endfunction

	function automatic conv_req_t count_req(input logic [63:0] c);
		conv_req_t r;
		r           = '0;
		r.req_type  = REQ_TO_DIGITS;
		r.count_in  = c[CNT_W-1:0];
		return r;
	endfunction

	function automatic conv_req_t digit_req(input logic [63:0] dg);
		conv_req_t r;
		r           = '0;
		r.req_type  = REQ_TO_COUNT;
		r.digits_in = dg;
		return r;
	endfunction

	function automatic conv_req_t random_request();
		conv_req_t   r;
		logic [63:0] wide;
		logic [63:0] cap;
		int unsigned kind;
		int unsigned ndig;
		int unsigned pos;
		int unsigned v;
		int unsigned badsel;
		cap   = pow9(NUM_DIGITS);
		kind  = $urandom_range(99);
		ndig  = $urandom_range(NUM_DIGITS, 1);
		wide  = {$urandom, $urandom};
		r.req_type  = 1'($urandom_range(1));
		r.count_in  = wide[CNT_W-1:0];
		r.digits_in = {$urandom, $urandom};
		if (r.req_type == REQ_TO_DIGITS) begin
			if (kind < 80) begin
				wide = {$urandom, $urandom};
				wide = wide % pow9(ndig);
				r.count_in = wide[CNT_W-1:0];
			end else if (kind < 90) begin
				// past the 16-digit capacity, up to the top of the count range
				wide = {$urandom, $urandom};
				wide = cap + wide % ((64'd1 << CNT_W) - cap);
				r.count_in = wide[CNT_W-1:0];
			end
		end else if (kind < 90) begin
			r.digits_in = '0;
			for (int unsigned i = 0; i < ndig; i++) begin
				v = $urandom_range(8);
				r.digits_in[4*i +: 4] = (v >= 4) ? 4'(v + 1) : 4'(v);
			end
			if (kind >= 75) begin
				pos    = $urandom_range(NUM_DIGITS - 1);
				badsel = $urandom_range(6);
				r.digits_in[4*pos +: 4] = (badsel == 0) ? SKIPPED_DIGIT : 4'(9 + badsel);
			end
		end
		return r;
	endfunction

	function automatic void report_mismatch(input string what, input conv_rsp_t want,
		input conv_rsp_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] %s: exp cnt=%0d dig=%h n=%0d bad=%0b, got cnt=%0d dig=%h n=%0d bad=%0b",
				$realtime, what, want.count_out, want.digits_out, want.digit_count,
				want.bad_input, got.count_out, got.digits_out, got.digit_count,
				got.bad_input);
	endfunction

	// called at a rising edge, returns at the edge where the item is taken
	task automatic send_item(input conv_req_t r);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= r.req_type;
		req_ch.count_in  <= r.count_in;
		req_ch.digits_in <= r.digits_in;
		do @(negedge clk); while (!req_ch.ready);
		@(posedge clk);
		expected_results.push_back(convert_expected(r));
	endtask

	// result side: ready stays stable between edges, so sample at the falling edge
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_seq) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (!arst_n) begin
				rsp_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got_result.count_out   = rsp_ch.count_out;
			got_result.digits_out  = rsp_ch.digits_out;
			got_result.digit_count = rsp_ch.digit_count;
			got_result.bad_input   = rsp_ch.bad_input;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected item", '0, got_result);
			end else begin
				want_result = expected_results.pop_front();
				if (got_result.count_out !== want_result.count_out)
					report_mismatch("count_out", want_result, got_result);
				else if (got_result.digits_out !== want_result.digits_out)
					report_mismatch("digits_out", want_result, got_result);
				else if (got_result.digit_count !== want_result.digit_count)
					report_mismatch("digit_count", want_result, got_result);
				else if (got_result.bad_input !== want_result.bad_input)
					report_mismatch("bad_input", want_result, got_result);
			end
		end
	end

	task automatic test_directed();
		logic [63:0] cap;
		conv_req_t   items[$];
		cap = pow9(NUM_DIGITS);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		items.push_back(count_req(64'd0));
		items.push_back(count_req(64'd1));
		items.push_back(count_req(64'd3));
		items.push_back(count_req(64'd4));
		items.push_back(count_req(64'd8));
		items.push_back(count_req(64'd9));
		items.push_back(count_req(64'd80));
		items.push_back(count_req(64'd81));
		items.push_back(count_req(cap - 64'd1));
		items.push_back(count_req(cap));
		items.push_back(count_req((64'd1 << CNT_W) - 64'd1));
		items.push_back(digit_req(64'h0));
		items.push_back(digit_req(64'h9999_9999_9999_9999));
		items.push_back(digit_req(64'h5));
		items.push_back(digit_req(64'h10));
		items.push_back(digit_req(64'h0123_5678_9012_3567));
		items.push_back(digit_req(64'h4));
		items.push_back(digit_req(64'h4000_0000_0000_0000));
		items.push_back(digit_req(64'hA0));
		items.push_back(digit_req(64'hFFFF_FFFF_FFFF_FFFF));
		foreach (items[i])
			send_item(items[i]);
	endtask

	task automatic test_random(input int unsigned n, input int unsigned tx_pct,
		input int unsigned rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (n)
			send_item(random_request());
	endtask

	// receiver stops for a long stretch while requests keep coming
	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_seq++;
		repeat (50)
			send_item(random_request());
	endtask

	initial begin
		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.req_type  <= REQ_TO_DIGITS;
		req_ch.count_in  <= '0;
		req_ch.digits_in <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(200, 36, 78);
		test_random(200, 78, 36);
		test_random(200, 0, 0);
		test_backpressure();

		req_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatches += expected_results.size();

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
